// ----- rtl/e2w_pkg.sv -----
// shared constants and types for the ecs to wcs arbitrary axis unit
// no dependencies; used by every module of the block
package e2w_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // unit vectors are q2.30
    localparam int UNIT_W    = 32;
    localparam int UNIT_FRAC = 30;

    // square sum and its root
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

    // helper axis switches to world y below 1/64 on both x and y of the normal
    localparam logic signed [UNIT_W-1:0] ARB_LIMIT = 32'sd16777216;

    // tuser bit positions on the result side
    localparam int USER_ZERO_BIT = 0;
    localparam int USER_SAT_BIT  = 1;
    localparam int USER_W        = 2;

    typedef logic signed [UNIT_W-1:0] unit_t;

    // result status, packed so that zero lands in bit 0
    typedef struct packed {
        logic sat;
        logic zero;
    } res_flags_t;

endpackage

// ----- rtl/ecs_to_wcs_arbitrary_axis_unit.sv -----
// top level of the ecs to wcs arbitrary axis unit: stream ports and stage wiring
// depends on e2w_pkg, e2w_unitize, e2w_cross and e2w_xform

// converts one entity-coordinate point per request into world coordinates using
// the arbitrary axis rule: the normal is made unit length, the helper axis is
// world y when both x and y of the unit normal are under 1/64 and world z
// otherwise, x = unit(helper x n), y = unit(n x x), and the result is
// px*x + py*y + pz*n rounded to nearest and clipped to the coordinate range.
// a new request can enter on every clock unless the pipe is frozen, and results
// leave in request order after three normalizers of 70 stages each (one stage per
// root bit and per quotient bit dominates), one helper axis stage, two cross
// product stages and three transform stages, the last of which is the output
// register. the whole pipe freezes while a result waits on m_tready, so
// s_tready follows m_tready whenever a result is held. a zero normal returns
// all-zero coordinates with zero_normal set.
module ecs_to_wcs_arbitrary_axis_unit #(
    parameter int COORD_WIDTH = e2w_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // normal_x, normal_y, normal_z, point_x, point_y, point_z from bit 0 up
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,

    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // world_x, world_y, world_z from bit 0 up
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
    // zero_normal, saturated from bit 0 up
    output logic [e2w_pkg::USER_W-1:0]              m_tuser
);
    import e2w_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int OUT_W = ((3*CW+7)/8)*8;
    localparam int PTS_W = 3 * CW;
    localparam int VEC_W = 3 * UNIT_W;
    localparam int SX_W  = PTS_W + VEC_W + 1;   // {zero, n, points}
    localparam int SY_W  = SX_W + VEC_W;        // {x axis, zero, n, points}

    // one enable for every stage: the pipe moves unless a result is held
    logic                      adv;

    logic signed [CW-1:0]      nvec [3];
    logic                      un_valid, un_zero;
    unit_t                     un_vec [3];
    logic [PTS_W-1:0]          un_side;

    logic                      use_y;
    logic                      hx_valid_reg;
    unit_t                     hx_tmp_reg [3];
    unit_t                     hx_tmp_next [3];
    logic [SX_W-1:0]           hx_side_reg;

    logic                      ux_valid;
    unit_t                     ux_vec [3];
    logic [SX_W-1:0]           ux_side;

    logic                      cr_valid;
    logic signed [2*UNIT_W-1:0] cr_vec [3];
    logic [SY_W-1:0]           cr_side;

    logic                      uy_valid;
    unit_t                     uy_vec [3];
    logic [SY_W-1:0]           uy_side;

    logic [3*CW-1:0]           world;
    res_flags_t                flags;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nvec[i] = s_tdata[i*CW +: CW];
        end
    end

    // normal to unit length, points ride along
    e2w_unitize #(.VW(CW), .SW(PTS_W)) u_unit_n (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_vec    (nvec),
        .in_side   (s_tdata[6*CW-1:3*CW]),
        .out_valid (un_valid),
        .out_vec   (un_vec),
        .out_zero  (un_zero),
        .out_side  (un_side)
    );

    // helper axis choice and helper x n
    always_comb begin
        use_y = (un_vec[0] > -ARB_LIMIT) && (un_vec[0] < ARB_LIMIT)
             && (un_vec[1] > -ARB_LIMIT) && (un_vec[1] < ARB_LIMIT);
        if (use_y) begin
            // world y x n
            hx_tmp_next[0] = un_vec[2];
            hx_tmp_next[1] = '0;
            hx_tmp_next[2] = -un_vec[0];
        end else begin
            // world z x n
            hx_tmp_next[0] = -un_vec[1];
            hx_tmp_next[1] = un_vec[0];
            hx_tmp_next[2] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hx_valid_reg <= 1'b0;
        end else if (adv) begin
            hx_valid_reg <= un_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hx_tmp_reg  <= hx_tmp_next;
            hx_side_reg <= {un_zero, un_vec[2], un_vec[1], un_vec[0], un_side};
        end
    end

    // x axis
    e2w_unitize #(.VW(UNIT_W), .SW(SX_W)) u_unit_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (hx_valid_reg),
        .in_vec    (hx_tmp_reg),
        .in_side   (hx_side_reg),
        .out_valid (ux_valid),
        .out_vec   (ux_vec),
        .out_zero  (),
        .out_side  (ux_side)
    );

    // n x x, still unnormalized
    e2w_cross #(.SW(SY_W)) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (ux_valid),
        .in_n      (ux_side[PTS_W +: VEC_W]),
        .in_x      (ux_vec),
        .in_side   ({ux_vec[2], ux_vec[1], ux_vec[0], ux_side}),
        .out_valid (cr_valid),
        .out_vec   (cr_vec),
        .out_side  (cr_side)
    );

    // y axis
    e2w_unitize #(.VW(2*UNIT_W), .SW(SY_W)) u_unit_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (cr_valid),
        .in_vec    (cr_vec),
        .in_side   (cr_side),
        .out_valid (uy_valid),
        .out_vec   (uy_vec),
        .out_zero  (),
        .out_side  (uy_side)
    );

    // world point, rounding and clipping, result register
    e2w_xform #(.CW(CW)) u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (uy_valid),
        .in_pts    (uy_side[PTS_W-1:0]),
        .in_ax     (uy_side[SX_W +: VEC_W]),
        .in_ay     ({uy_vec[2], uy_vec[1], uy_vec[0]}),
        .in_an     (uy_side[PTS_W +: VEC_W]),
        .in_zero   (uy_side[PTS_W+VEC_W]),
        .out_valid (m_tvalid),
        .out_world (world),
        .out_flags (flags)
    );

    assign m_tdata = OUT_W'(world);
    assign m_tuser = flags;

endmodule

// ----- rtl/e2w_unitize.sv -----
// pipelined vector normalizer: leading-one scaling, square sum, bit-serial root
// and restoring divide, one stage per root or quotient bit; uses e2w_pkg
module e2w_unitize #(
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [VW-1:0]  in_vec [3],
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output e2w_pkg::unit_t        out_vec [3],
    output logic                  out_zero,
    output logic [SW-1:0]         out_side
);
    import e2w_pkg::*;

    localparam int PW     = (VW > 1) ? $clog2(VW) : 1;
    localparam int NA     = UNIT_FRAC + 1;
    localparam int AW     = (VW > NA) ? VW : NA;
    localparam int SQ_W   = 2 * NA;
    localparam int CAND_W = SUM_W + 2;
    localparam int NUM_W  = NA + UNIT_FRAC + 2;
    localparam int CAR_W  = SW + 4;
    localparam int NSQ    = ROOT_W;
    localparam int NDV    = NA;
    localparam int NSTG   = NSQ + NDV + 7;
    localparam int ZB     = 3;

    // carry word: {side, zero, neg[2:0]}
    logic [NSTG-1:0]    vld_reg;

    logic [VW-1:0]      f1_mag_reg [3];
    logic [VW-1:0]      f1_mag_next [3];
    logic [VW-1:0]      f1_max_reg, f1_max_next, m01;
    logic [CAR_W-1:0]   f1_car_reg, f1_car_next;

    logic [PW-1:0]      f2_pos_reg, f2_pos_next;
    logic [VW-1:0]      f2_mag_reg [3];
    logic [CAR_W-1:0]   f2_car_reg;

    logic [6:0]         pos7;
    logic [AW-1:0]      ext [3];
    logic [AW-1:0]      shf [3];
    logic [NA-1:0]      f3_a_reg [3];
    logic [NA-1:0]      f3_a_next [3];
    logic [CAR_W-1:0]   f3_car_reg;

    logic [SQ_W-1:0]    f4_sq_reg [3];
    logic [SQ_W-1:0]    f4_sq_next [3];
    logic [NA-1:0]      f4_a_reg [3];
    logic [CAR_W-1:0]   f4_car_reg;

    logic [SUM_W-1:0]   sr_rem_reg [0:NSQ];
    logic [SUM_W-1:0]   sr_rem_next [0:NSQ];
    logic [ROOT_W-1:0]  sr_root_reg [0:NSQ];
    logic [ROOT_W-1:0]  sr_root_next [0:NSQ];
    logic [NA-1:0]      sr_a_reg [0:NSQ][3];
    logic [CAR_W-1:0]   sr_car_reg [0:NSQ];
    logic [CAND_W-1:0]  cand [1:NSQ];

    logic [NUM_W-1:0]   dv_rem_reg [0:NDV][3];
    logic [NUM_W-1:0]   dv_rem_next [0:NDV][3];
    logic [NA-1:0]      dv_q_reg [0:NDV][3];
    logic [NA-1:0]      dv_q_next [0:NDV][3];
    logic [ROOT_W-1:0]  dv_div_reg [0:NDV];
    logic [CAR_W-1:0]   dv_car_reg [0:NDV];
    logic [NUM_W-1:0]   dsh [1:NDV];

    unit_t              qv [3];
    unit_t              out_vec_reg [3];
    unit_t              out_vec_next [3];
    logic               out_zero_reg;
    logic [SW-1:0]      out_side_reg;

    always_comb begin
        // magnitudes and largest one
        for (int i = 0; i < 3; i++) begin
            f1_mag_next[i] = in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
        end
        m01 = (f1_mag_next[0] > f1_mag_next[1]) ? f1_mag_next[0] : f1_mag_next[1];
        f1_max_next = (m01 > f1_mag_next[2]) ? m01 : f1_mag_next[2];
        f1_car_next = {in_side, ~|{in_vec[0], in_vec[1], in_vec[2]},
                       in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1]};

        // leading one of the largest magnitude
        f2_pos_next = '0;
        for (int b = 0; b < VW; b++) begin
            if (f1_max_reg[b]) f2_pos_next = PW'(b);
        end

        // scale so the largest lands in [2^30, 2^31), right shifts truncate
        pos7 = 7'(f2_pos_reg);
        for (int i = 0; i < 3; i++) begin
            ext[i] = AW'(f2_mag_reg[i]);
            if (pos7 >= 7'(UNIT_FRAC)) begin
                shf[i] = ext[i] >> (pos7 - 7'(UNIT_FRAC));
            end else begin
                shf[i] = ext[i] << (7'(UNIT_FRAC) - pos7);
            end
            f3_a_next[i] = shf[i][NA-1:0];
        end

        for (int i = 0; i < 3; i++) begin
            f4_sq_next[i] = SQ_W'(f3_a_reg[i]) * SQ_W'(f3_a_reg[i]);
        end

        // square sum feeds the root pipe
        sr_rem_next[0]  = SUM_W'(f4_sq_reg[0]) + SUM_W'(f4_sq_reg[1]) + SUM_W'(f4_sq_reg[2]);
        sr_root_next[0] = '0;
        for (int j = 1; j <= NSQ; j++) begin
            cand[j] = (CAND_W'(sr_root_reg[j-1]) << (NSQ - j + 1))
                    | (CAND_W'(1) << (2 * (NSQ - j)));
            if (CAND_W'(sr_rem_reg[j-1]) >= cand[j]) begin
                sr_rem_next[j]  = sr_rem_reg[j-1] - cand[j][SUM_W-1:0];
                sr_root_next[j] = sr_root_reg[j-1] | (ROOT_W'(1) << (NSQ - j));
            end else begin
                sr_rem_next[j]  = sr_rem_reg[j-1];
                sr_root_next[j] = sr_root_reg[j-1];
            end
        end

        // rounded quotient a * 2^30 / r, numerator carries half the divisor
        for (int i = 0; i < 3; i++) begin
            dv_rem_next[0][i] = NUM_W'({sr_a_reg[NSQ][i], {UNIT_FRAC{1'b0}}})
                              + NUM_W'(sr_root_reg[NSQ] >> 1);
            dv_q_next[0][i]   = '0;
        end
        for (int j = 1; j <= NDV; j++) begin
            dsh[j] = NUM_W'(dv_div_reg[j-1]) << (NDV - j);
            for (int i = 0; i < 3; i++) begin
                if (dv_rem_reg[j-1][i] >= dsh[j]) begin
                    dv_rem_next[j][i] = dv_rem_reg[j-1][i] - dsh[j];
                    dv_q_next[j][i]   = dv_q_reg[j-1][i] | (NA'(1) << (NDV - j));
                end else begin
                    dv_rem_next[j][i] = dv_rem_reg[j-1][i];
                    dv_q_next[j][i]   = dv_q_reg[j-1][i];
                end
            end
        end

        // restore signs, zero vector gives zero axis
        for (int i = 0; i < 3; i++) begin
            qv[i] = UNIT_W'(dv_q_reg[NDV][i]);
            if (dv_car_reg[NDV][ZB]) begin
                out_vec_next[i] = '0;
            end else if (dv_car_reg[NDV][i]) begin
                out_vec_next[i] = -qv[i];
            end else begin
                out_vec_next[i] = qv[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_mag_reg <= f1_mag_next;
            f1_max_reg <= f1_max_next;
            f1_car_reg <= f1_car_next;

            f2_pos_reg <= f2_pos_next;
            f2_mag_reg <= f1_mag_reg;
            f2_car_reg <= f1_car_reg;

            f3_a_reg   <= f3_a_next;
            f3_car_reg <= f2_car_reg;

            f4_sq_reg  <= f4_sq_next;
            f4_a_reg   <= f3_a_reg;
            f4_car_reg <= f3_car_reg;

            sr_rem_reg[0]  <= sr_rem_next[0];
            sr_root_reg[0] <= sr_root_next[0];
            sr_a_reg[0]    <= f4_a_reg;
            sr_car_reg[0]  <= f4_car_reg;
            for (int j = 1; j <= NSQ; j++) begin
                sr_rem_reg[j]  <= sr_rem_next[j];
                sr_root_reg[j] <= sr_root_next[j];
                sr_a_reg[j]    <= sr_a_reg[j-1];
                sr_car_reg[j]  <= sr_car_reg[j-1];
            end

            dv_rem_reg[0] <= dv_rem_next[0];
            dv_q_reg[0]   <= dv_q_next[0];
            dv_div_reg[0] <= sr_root_reg[NSQ];
            dv_car_reg[0] <= sr_car_reg[NSQ];
            for (int j = 1; j <= NDV; j++) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
                dv_div_reg[j] <= dv_div_reg[j-1];
                dv_car_reg[j] <= dv_car_reg[j-1];
            end

            out_vec_reg  <= out_vec_next;
            out_zero_reg <= dv_car_reg[NDV][ZB];
            out_side_reg <= dv_car_reg[NDV][CAR_W-1:4];
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_vec   = out_vec_reg;
    assign out_zero  = out_zero_reg;
    assign out_side  = out_side_reg;

endmodule

// ----- rtl/e2w_cross.sv -----
// two-stage cross product n x x of q2.30 unit vectors into a 64-bit vector
// uses e2w_pkg
module e2w_cross #(
    parameter int SW = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [3*e2w_pkg::UNIT_W-1:0]  in_n,
    input  e2w_pkg::unit_t                in_x [3],
    input  logic [SW-1:0]                 in_side,
    output logic                          out_valid,
    output logic signed [2*e2w_pkg::UNIT_W-1:0] out_vec [3],
    output logic [SW-1:0]                 out_side
);
    import e2w_pkg::*;

    localparam int PR_W = 2 * UNIT_W;

    logic [1:0]               vld_reg;
    unit_t                    nv [3];
    logic signed [PR_W-1:0]   pr_reg [6];
    logic signed [PR_W-1:0]   pr_next [6];
    logic signed [PR_W-1:0]   vec_reg [3];
    logic [SW-1:0]            side_reg [2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nv[i] = in_n[i*UNIT_W +: UNIT_W];
        end
        pr_next[0] = PR_W'(nv[1]) * PR_W'(in_x[2]);
        pr_next[1] = PR_W'(nv[2]) * PR_W'(in_x[1]);
        pr_next[2] = PR_W'(nv[2]) * PR_W'(in_x[0]);
        pr_next[3] = PR_W'(nv[0]) * PR_W'(in_x[2]);
        pr_next[4] = PR_W'(nv[0]) * PR_W'(in_x[1]);
        pr_next[5] = PR_W'(nv[1]) * PR_W'(in_x[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg      <= pr_next;
            side_reg[0] <= in_side;
            vec_reg[0]  <= pr_reg[0] - pr_reg[1];
            vec_reg[1]  <= pr_reg[2] - pr_reg[3];
            vec_reg[2]  <= pr_reg[4] - pr_reg[5];
            side_reg[1] <= side_reg[0];
        end
    end

    assign out_valid = vld_reg[1];
    assign out_vec   = vec_reg;
    assign out_side  = side_reg[1];

endmodule

// ----- rtl/e2w_xform.sv -----
// three-stage point transform: split products, column sums, round and saturate
// the last stage is the result register; uses e2w_pkg
module e2w_xform #(
    parameter int CW = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [3*CW-1:0]               in_pts,
    input  logic [3*e2w_pkg::UNIT_W-1:0]  in_ax,
    input  logic [3*e2w_pkg::UNIT_W-1:0]  in_ay,
    input  logic [3*e2w_pkg::UNIT_W-1:0]  in_an,
    input  logic                          in_zero,
    output logic                          out_valid,
    output logic [3*CW-1:0]               out_world,
    output e2w_pkg::res_flags_t           out_flags
);
    import e2w_pkg::*;

    localparam int LO_W = CW / 2;
    localparam int HI_W = CW - LO_W;
    localparam int HP_W = HI_W + UNIT_W;
    localparam int LP_W = LO_W + 1 + UNIT_W;
    localparam int HS_W = HP_W + 2;
    localparam int LS_W = LP_W + 2;
    localparam int TW   = CW + UNIT_W + 4;
    localparam int RW   = TW - UNIT_FRAC;
    localparam logic signed [RW-1:0] MAXV =
        signed'({{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [RW-1:0] MINV = ~MAXV;

    logic [2:0]               vld_reg;
    unit_t                    axv [3][3];
    logic signed [HI_W-1:0]   ph [3];
    logic signed [LO_W:0]     pl [3];
    logic signed [HP_W-1:0]   hp_reg [3][3];
    logic signed [HP_W-1:0]   hp_next [3][3];
    logic signed [LP_W-1:0]   lp_reg [3][3];
    logic signed [LP_W-1:0]   lp_next [3][3];
    logic [1:0]               zero_reg;
    logic signed [HS_W-1:0]   hs_reg [3];
    logic signed [HS_W-1:0]   hs_next [3];
    logic signed [LS_W-1:0]   ls_reg [3];
    logic signed [LS_W-1:0]   ls_next [3];
    logic signed [TW-1:0]     total [3];
    logic signed [RW-1:0]     res [3];
    logic [2:0]               satc;
    logic [3*CW-1:0]          world_reg, world_next;
    res_flags_t               flags_reg, flags_next;

    always_comb begin
        // axv[i][c]: component c of the axis that point coordinate i scales
        for (int c = 0; c < 3; c++) begin
            axv[0][c] = in_ax[c*UNIT_W +: UNIT_W];
            axv[1][c] = in_ay[c*UNIT_W +: UNIT_W];
            axv[2][c] = in_an[c*UNIT_W +: UNIT_W];
        end
        for (int i = 0; i < 3; i++) begin
            ph[i] = in_pts[i*CW+LO_W +: HI_W];
            pl[i] = {1'b0, in_pts[i*CW +: LO_W]};
        end
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                hp_next[c][i] = HP_W'(ph[i]) * HP_W'(axv[i][c]);
                lp_next[c][i] = LP_W'(pl[i]) * LP_W'(axv[i][c]);
            end
        end

        for (int c = 0; c < 3; c++) begin
            hs_next[c] = HS_W'(hp_reg[c][0]) + HS_W'(hp_reg[c][1]) + HS_W'(hp_reg[c][2]);
            ls_next[c] = LS_W'(lp_reg[c][0]) + LS_W'(lp_reg[c][1]) + LS_W'(lp_reg[c][2]);
        end

        // round to nearest, ties up, then clip
        for (int c = 0; c < 3; c++) begin
            total[c] = (TW'(hs_reg[c]) <<< LO_W) + TW'(ls_reg[c])
                     + (TW'(1) <<< (UNIT_FRAC - 1));
            res[c]   = RW'(total[c] >>> UNIT_FRAC);
            satc[c]  = 1'b0;
            if (zero_reg[1]) begin
                world_next[c*CW +: CW] = '0;
            end else if (res[c] > MAXV) begin
                world_next[c*CW +: CW] = MAXV[CW-1:0];
                satc[c] = 1'b1;
            end else if (res[c] < MINV) begin
                world_next[c*CW +: CW] = MINV[CW-1:0];
                satc[c] = 1'b1;
            end else begin
                world_next[c*CW +: CW] = res[c][CW-1:0];
            end
        end
        flags_next.zero = zero_reg[1];
        flags_next.sat  = |satc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hp_reg    <= hp_next;
            lp_reg    <= lp_next;
            zero_reg  <= {zero_reg[0], in_zero};
            hs_reg    <= hs_next;
            ls_reg    <= ls_next;
            world_reg <= world_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_world = world_reg;
    assign out_flags = flags_reg;

endmodule

// ----- rtl/e2w_checker.sv -----
// port-level checks for the ecs to wcs arbitrary axis unit, bound to the top level
// depends on e2w_pkg and ecs_to_wcs_arbitrary_axis_unit
module e2w_checker #(
    parameter int COORD_WIDTH = e2w_pkg::COORD_WIDTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    input logic [e2w_pkg::USER_W-1:0]          m_tuser
);
    import e2w_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINC = ~MAXC;

    // a held result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an empty result side never blocks requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with no result pending");

    // zero normal gives zero coordinates and no clipping
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_ZERO_BIT] |-> m_tdata == '0 && !m_tuser[USER_SAT_BIT])
        else $error("zero normal with nonzero result");

    // clipping shows as at least one coordinate at an extreme
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_SAT_BIT] |->
            m_tdata[CW-1:0] == MAXC || m_tdata[CW-1:0] == MINC ||
            m_tdata[2*CW-1:CW] == MAXC || m_tdata[2*CW-1:CW] == MINC ||
            m_tdata[3*CW-1:2*CW] == MAXC || m_tdata[3*CW-1:2*CW] == MINC)
        else $error("saturated flag without a clipped coordinate");

endmodule

bind ecs_to_wcs_arbitrary_axis_unit e2w_checker #(.COORD_WIDTH(COORD_WIDTH)) u_e2w_checker (.*);
